### hw/rtl/glpf_pkg.sv
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared constants, types and controller encoding for the grid peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

  localparam int unsigned MaxColsDef     = 32;
  localparam int unsigned MaxRowsDef     = 32;
  localparam int unsigned SampleWidthDef = 32;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned PosOutW  = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CTR,
    ST_RD_RIGHT,
    ST_EVAL,
    ST_W_CTR,
    ST_W_RIGHT,
    ST_W_EVAL,
    ST_FLUSH
  } glpf_state_e;

  typedef struct packed {
    logic load;       // capture sample and its position
    logic rd_ctr;     // read center and upper entries
    logic rd_right;   // read right neighbour entry
    logic eval_main;  // decide sample above, update line stores
    logic eval_walk;  // decide one entry of the last row
    logic flush;      // release held result as last of run
  } glpf_cmd_t;

  typedef struct packed {
    logic stall;       // result found but output path full
    logic frame_end;   // current item is the final sample of the frame
    logic walk_done;   // last-row walk is at its last column
    logic flush_busy;  // held result cannot move yet
  } glpf_status_t;

endpackage

### hw/rtl/glpf_if.sv
// ----------------------------------------------------------------------------
// glpf_if
// Valid/ready channels for grid samples and for reported peaks.
// ----------------------------------------------------------------------------
interface glpf_sample_if #(
  parameter int unsigned SampleWidth = glpf_pkg::SampleWidthDef
) ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface glpf_peak_if ();
  logic                         valid;
  logic                         ready;
  logic [glpf_pkg::PosOutW-1:0] peak_row;
  logic [glpf_pkg::PosOutW-1:0] peak_col;
  logic                         last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                  output ready);
endinterface

### hw/rtl/glpf_ctrl.sv
// ----------------------------------------------------------------------------
// glpf_ctrl
// Sequencer: per-item read/evaluate steps and the end-of-frame row walk.
// ----------------------------------------------------------------------------
module glpf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  glpf_pkg::glpf_status_t status_i,
  output glpf_pkg::glpf_cmd_t    cmd_o
);

  glpf_pkg::glpf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      glpf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = glpf_pkg::ST_RD_CTR;
      end
      glpf_pkg::ST_RD_CTR:   state_d = glpf_pkg::ST_RD_RIGHT;
      glpf_pkg::ST_RD_RIGHT: state_d = glpf_pkg::ST_EVAL;
      glpf_pkg::ST_EVAL: begin
        if (!status_i.stall) begin
          state_d = status_i.frame_end ? glpf_pkg::ST_W_CTR : glpf_pkg::ST_FLUSH;
        end
      end
      glpf_pkg::ST_W_CTR:   state_d = glpf_pkg::ST_W_RIGHT;
      glpf_pkg::ST_W_RIGHT: state_d = glpf_pkg::ST_W_EVAL;
      glpf_pkg::ST_W_EVAL: begin
        if (!status_i.stall) begin
          state_d = status_i.walk_done ? glpf_pkg::ST_FLUSH : glpf_pkg::ST_W_CTR;
        end
      end
      glpf_pkg::ST_FLUSH: begin
        if (!status_i.flush_busy) state_d = glpf_pkg::ST_IDLE;
      end
      default: state_d = glpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == glpf_pkg::ST_IDLE);
    cmd_o           = '0;
    cmd_o.load      = (state_q == glpf_pkg::ST_IDLE) && in_valid_i;
    cmd_o.rd_ctr    = (state_q == glpf_pkg::ST_RD_CTR) || (state_q == glpf_pkg::ST_W_CTR);
    cmd_o.rd_right  = (state_q == glpf_pkg::ST_RD_RIGHT) || (state_q == glpf_pkg::ST_W_RIGHT);
    cmd_o.eval_main = (state_q == glpf_pkg::ST_EVAL);
    cmd_o.eval_walk = (state_q == glpf_pkg::ST_W_EVAL);
    cmd_o.flush     = (state_q == glpf_pkg::ST_FLUSH);
  end

endmodule

### hw/rtl/glpf_dp.sv
// ----------------------------------------------------------------------------
// glpf_dp
// Line stores, position counters, neighbour compare and result holding.
// ----------------------------------------------------------------------------
module glpf_dp #(
  parameter int unsigned MaxCols     = glpf_pkg::MaxColsDef,
  parameter int unsigned MaxRows     = glpf_pkg::MaxRowsDef,
  parameter int unsigned SampleWidth = glpf_pkg::SampleWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [glpf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [glpf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [SampleWidth-1:0]           sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [glpf_pkg::PosOutW-1:0]     out_row_o,
  output logic [glpf_pkg::PosOutW-1:0]     out_col_o,
  output logic                             out_last_o,
  input  glpf_pkg::glpf_cmd_t              cmd_i,
  output glpf_pkg::glpf_status_t           status_o
);

  localparam int unsigned ColAw = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned RowAw = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColDimW = ($clog2(MaxCols + 1) > glpf_pkg::CfgDataW) ?
                                    $clog2(MaxCols + 1) : glpf_pkg::CfgDataW;
  localparam int unsigned RowDimW = ($clog2(MaxRows + 1) > glpf_pkg::CfgDataW) ?
                                    $clog2(MaxRows + 1) : glpf_pkg::CfgDataW;

  logic [glpf_pkg::CfgDataW-1:0] num_rows_q, num_cols_q;
  logic [RowAw-1:0]              pos_r_q, cur_r_q;
  logic [ColAw-1:0]              pos_c_q, cur_c_q;

  logic [SampleWidth-1:0] mem_recent [MaxCols];
  logic [SampleWidth-1:0] mem_older  [MaxCols];
  logic [SampleWidth-1:0] rd_recent_q, rd_older_q;
  logic [SampleWidth-1:0] v_q, center_q, left_q;

  logic                         pend_valid_q;
  logic [glpf_pkg::PosOutW-1:0] pend_row_q, pend_col_q;
  logic                         out_valid_q, out_last_q;
  logic [glpf_pkg::PosOutW-1:0] out_row_q, out_col_q;

  logic [ColDimW-1:0] cols_eff;
  logic [RowDimW-1:0] rows_eff;
  logic [ColAw-1:0]   col_last, right_addr;
  logic [RowAw-1:0]   row_last;
  logic               ge_down, ge_up, ge_left, ge_right;
  logic               ok_left, ok_right, peak_main, peak_walk, peak;
  logic               step, push_ok, push_mid, push_end, mem_we;
  logic [glpf_pkg::PosOutW-1:0] new_row;

  // Zero means one; values above the store size clamp to it.
  always_comb begin
    if (num_cols_q == '0) begin
      cols_eff = ColDimW'(1);
    end else if (ColDimW'(num_cols_q) > ColDimW'(MaxCols)) begin
      cols_eff = ColDimW'(MaxCols);
    end else begin
      cols_eff = ColDimW'(num_cols_q);
    end
    if (num_rows_q == '0) begin
      rows_eff = RowDimW'(1);
    end else if (RowDimW'(num_rows_q) > RowDimW'(MaxRows)) begin
      rows_eff = RowDimW'(MaxRows);
    end else begin
      rows_eff = RowDimW'(num_rows_q);
    end
  end

  assign col_last   = ColAw'(cols_eff - ColDimW'(1));
  assign row_last   = RowAw'(rows_eff - RowDimW'(1));
  assign right_addr = (cur_c_q == col_last) ? cur_c_q : cur_c_q + ColAw'(1);

  // Neighbour compares; center is the row above the current item (or last row on walk).
  assign ge_down  = $signed(center_q) >= $signed(v_q);
  assign ge_up    = $signed(center_q) >= $signed(rd_older_q);
  assign ge_left  = $signed(center_q) >= $signed(left_q);
  assign ge_right = $signed(center_q) >= $signed(rd_recent_q);
  assign ok_left  = (cur_c_q == '0) || ge_left;
  assign ok_right = (cur_c_q == col_last) || ge_right;

  assign peak_main = (cur_r_q != '0) && ge_down && ((cur_r_q < 2) || ge_up) &&
                     ok_left && ok_right;
  assign peak_walk = ((cur_r_q == '0) || ge_up) && ok_left && ok_right;
  assign peak      = (cmd_i.eval_main && peak_main) || (cmd_i.eval_walk && peak_walk);
  assign new_row   = cmd_i.eval_main ? glpf_pkg::PosOutW'(cur_r_q - RowAw'(1)) :
                                       glpf_pkg::PosOutW'(cur_r_q);

  assign push_ok  = !out_valid_q || out_ready_i;
  assign status_o.stall      = peak && pend_valid_q && !push_ok;
  assign status_o.flush_busy = pend_valid_q && !push_ok;
  assign status_o.frame_end  = (cur_c_q == col_last) && (cur_r_q == row_last);
  assign status_o.walk_done  = (cur_c_q == col_last);

  assign step     = (cmd_i.eval_main || cmd_i.eval_walk) && !status_o.stall;
  assign push_mid = step && peak && pend_valid_q;
  assign push_end = cmd_i.flush && pend_valid_q && push_ok;
  assign mem_we   = cmd_i.eval_main && !status_o.stall;

  // Line stores: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ctr) begin
      rd_recent_q <= mem_recent[cur_c_q];
      rd_older_q  <= mem_older[cur_c_q];
    end else if (cmd_i.rd_right) begin
      rd_recent_q <= mem_recent[right_addr];
    end
    if (mem_we) begin
      mem_older[cur_c_q]  <= center_q;
      mem_recent[cur_c_q] <= v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) v_q <= sample_i;
    if (cmd_i.rd_right) center_q <= rd_recent_q;
    if (step) left_q <= center_q;
    if (step && peak) begin
      pend_row_q <= new_row;
      pend_col_q <= glpf_pkg::PosOutW'(cur_c_q);
    end
    if (push_mid || push_end) begin
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_last_q <= push_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q   <= glpf_pkg::CfgDataW'(1);
      num_cols_q   <= glpf_pkg::CfgDataW'(1);
      pos_r_q      <= '0;
      pos_c_q      <= '0;
      cur_r_q      <= '0;
      cur_c_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (glpf_pkg::cfg_reg_e'(cfg_idx_i))
          glpf_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data_i;
          glpf_pkg::REG_NUM_COLS: num_cols_q <= cfg_data_i;
          default: ;
        endcase
        pos_r_q <= '0;
        pos_c_q <= '0;
      end

      if (cmd_i.load) begin
        if ((pos_r_q > row_last) || (pos_c_q > col_last)) begin
          cur_r_q <= '0;
          cur_c_q <= '0;
        end else begin
          cur_r_q <= pos_r_q;
          cur_c_q <= pos_c_q;
        end
      end

      if (cmd_i.eval_main && !status_o.stall) begin
        if (cur_c_q != col_last) begin
          pos_c_q <= cur_c_q + ColAw'(1);
          pos_r_q <= cur_r_q;
        end else begin
          pos_c_q <= '0;
          pos_r_q <= (cur_r_q != row_last) ? cur_r_q + RowAw'(1) : '0;
          cur_c_q <= '0;  // walk of the last row starts at column zero
        end
      end

      if (cmd_i.eval_walk && !status_o.stall && (cur_c_q != col_last)) begin
        cur_c_q <= cur_c_q + ColAw'(1);
      end

      // One result is held back so the final one of a run can be flagged.
      if (step && peak) begin
        pend_valid_q <= 1'b1;
      end else if (push_end) begin
        pend_valid_q <= 1'b0;
      end

      if (push_mid || push_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

endmodule

### hw/rtl/grid_local_peak_finder.sv
// Items are taken one at a time: registered reads of the line stores (center,
//   then right neighbour), evaluate, then release of the held result. The final
//   sample of a frame also walks the last row: center read, right read and
//   evaluate for each column. Output back-pressure stalls the block whenever a
//   held result must move to a full output (a second found result or the flush).
// Reset (rst_ni, async low): num_rows = num_cols = 1, position row 0 column 0.
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// Streams a grid row by row and reports 4-neighbour local maxima in order.
// ----------------------------------------------------------------------------
module grid_local_peak_finder #(
  parameter int unsigned MaxCols     = glpf_pkg::MaxColsDef,
  parameter int unsigned MaxRows     = glpf_pkg::MaxRowsDef,
  parameter int unsigned SampleWidth = glpf_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [glpf_pkg::CfgDataW-1:0] cfg_data_i,
  glpf_sample_if.sink                   sample_i,
  glpf_peak_if.source                   peak_o
);

  glpf_pkg::glpf_cmd_t    cmd;
  glpf_pkg::glpf_status_t status;

  glpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glpf_dp #(
    .MaxCols     (MaxCols),
    .MaxRows     (MaxRows),
    .SampleWidth (SampleWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i.sample),
    .out_ready_i (peak_o.ready),
    .out_valid_o (peak_o.valid),
    .out_row_o   (peak_o.peak_row),
    .out_col_o   (peak_o.peak_col),
    .out_last_o  (peak_o.last_of_run),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

### hw/rtl/glpf_checker.sv
// ----------------------------------------------------------------------------
// glpf_checker
// Port-level checks on the peak finder's channels, bound to the top level.
// ----------------------------------------------------------------------------
module glpf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [glpf_pkg::PosOutW-1:0] out_row_i,
  input logic [glpf_pkg::PosOutW-1:0] out_col_i,
  input logic                         out_last_i
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_row_i) && $stable(out_col_i) &&
                                    $stable(out_last_i))
    else $error("result payload changed while stalled");

  // One item at a time: no accept in the cycle after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // While a run is still open, no new item is taken.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready before the run was closed");

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (peak_o.valid),
  .out_ready_i (peak_o.ready),
  .out_row_i   (peak_o.peak_row),
  .out_col_i   (peak_o.peak_col),
  .out_last_i  (peak_o.last_of_run)
);

### tb/glpf_peak_checker.sv
// ----------------------------------------------------------------------------
// glpf_peak_checker
// Watches the config port and both channels of the grid peak finder. Keeps its
// own line stores and frame position, works out the peaks each accepted sample
// decides, and compares every accepted peak with the oldest one still pending.
// ----------------------------------------------------------------------------
module glpf_peak_checker
  import glpf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      sample_valid_i,
  input  logic                      sample_ready_i,
  input  logic [SampleWidthDef-1:0] sample_i,
  input  logic                      peak_valid_i,
  input  logic                      peak_ready_i,
  input  logic [PosOutW-1:0]        peak_row_i,
  input  logic [PosOutW-1:0]        peak_col_i,
  input  logic                      peak_last_i,
  output int                        outstanding_o,
  output int                        mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosOutW-1:0] row;
    logic [PosOutW-1:0] col;
    logic               last;
  } peak_t;

  peak_t                            expected_peaks[$];
  logic signed [SampleWidthDef-1:0] older_row [MaxColsDef];
  logic signed [SampleWidthDef-1:0] upper_row [MaxColsDef];
  logic [CfgDataW-1:0]              rows_raw;
  logic [CfgDataW-1:0]              cols_raw;
  int unsigned                      row_at;
  int unsigned                      col_at;
  int                               mismatch_cnt;

  assign mismatch_count_o = mismatch_cnt;

  function automatic int unsigned grid_dim(input logic [CfgDataW-1:0] raw,
                                           input int unsigned lim);
    if (raw == '0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Decide the cell above the new sample; on the last sample also walk the
  // bottom row. Results of one sample go out in row-major order.
  function automatic void predict_peaks(input logic signed [SampleWidthDef-1:0] v);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    logic        ok;
    logic signed [SampleWidthDef-1:0] ctr;
    peak_t       found[$];
    peak_t       p;
    rows = grid_dim(rows_raw, MaxRowsDef);
    cols = grid_dim(cols_raw, MaxColsDef);
    r = row_at;
    c = col_at;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    if (r >= 1) begin
      ctr = upper_row[c];
      ok = (ctr >= v);
      if (r >= 2 && ctr < older_row[c]) ok = 1'b0;
      if (c >= 1 && ctr < older_row[c-1]) ok = 1'b0;
      if (c + 1 < cols && ctr < upper_row[c+1]) ok = 1'b0;
      if (ok) begin
        p.row = PosOutW'(r - 1);
        p.col = PosOutW'(c);
        p.last = 1'b0;
        found.push_back(p);
      end
    end
    older_row[c] = upper_row[c];
    upper_row[c] = v;
    if (c + 1 < cols) begin
      c++;
    end else begin
      c = 0;
      if (r + 1 < rows) begin
        r++;
      end else begin
        for (int unsigned j = 0; j < cols; j++) begin
          ctr = upper_row[j];
          ok = 1'b1;
          if (r >= 1 && ctr < older_row[j]) ok = 1'b0;
          if (j >= 1 && ctr < upper_row[j-1]) ok = 1'b0;
          if (j + 1 < cols && ctr < upper_row[j+1]) ok = 1'b0;
          if (ok) begin
            p.row = PosOutW'(r);
            p.col = PosOutW'(j);
            p.last = 1'b0;
            found.push_back(p);
          end
        end
        r = 0;
      end
    end
    row_at = r;
    col_at = c;
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_peaks.push_back(found[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    peak_t want;
    if (!rst_ni) begin
      expected_peaks.delete();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        upper_row[i] = '0;
      end
      rows_raw = CfgDataW'(1);
      cols_raw = CfgDataW'(1);
      row_at = 0;
      col_at = 0;
      mismatch_cnt = 0;
      outstanding_o <= 0;
    end else begin
      if (peak_valid_i && peak_ready_i) begin
        if (expected_peaks.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected peak: expected none, got row %0d col %0d last %0b",
                   $time, peak_row_i, peak_col_i, peak_last_i);
        end else begin
          want = expected_peaks.pop_front();
          if (want.row !== peak_row_i || want.col !== peak_col_i ||
              want.last !== peak_last_i) begin
            mismatch_cnt++;
            $display("%0t: peak mismatch: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                     $time, want.row, want.col, want.last,
                     peak_row_i, peak_col_i, peak_last_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_NUM_ROWS: rows_raw = cfg_data_i;
          REG_NUM_COLS: cols_raw = cfg_data_i;
          default: ;
        endcase
        // any register write restarts the frame
        row_at = 0;
        col_at = 0;
      end
      if (sample_valid_i && sample_ready_i) predict_peaks(sample_i);
      outstanding_o <= expected_peaks.size();
    end
  end

endmodule

### tb/grid_local_peak_finder_tb.sv
// ----------------------------------------------------------------------------
// grid_local_peak_finder_tb
// Streams grids of many shapes through the peak finder with random bursts and
// output stalls, reprogramming the grid size between runs; a checker beside
// the block predicts and compares every reported peak.
// ----------------------------------------------------------------------------
module grid_local_peak_finder_tb;
  import glpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned StallLimit   = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  outstanding;
  int                  mismatches;
  int unsigned         burst_left;
  int unsigned         idle_cycles;

  glpf_sample_if sample_ch ();
  glpf_peak_if   peak_ch ();

  always #2 clk_i = ~clk_i;

  grid_local_peak_finder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (sample_ch),
    .peak_o     (peak_ch)
  );

  glpf_peak_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .sample_valid_i   (sample_ch.valid),
    .sample_ready_i   (sample_ch.ready),
    .sample_i         (sample_ch.sample),
    .peak_valid_i     (peak_ch.valid),
    .peak_ready_i     (peak_ch.ready),
    .peak_row_i       (peak_ch.peak_row),
    .peak_col_i       (peak_ch.peak_col),
    .peak_last_i      (peak_ch.last_of_run),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatches)
  );

  // Output side: each stretch picks its own stall pattern.
  initial begin : drain_pattern
    int unsigned mode;
    int unsigned span;
    int unsigned period;
    int unsigned tick;
    peak_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      period = $urandom_range(2, 5);
      tick = 0;
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: peak_ch.ready <= 1'b1;
          1: peak_ch.ready <= ($urandom_range(0, 1) == 1);
          2: peak_ch.ready <= ($urandom_range(0, 3) == 0);
          default: peak_ch.ready <= (tick % period == 0);
        endcase
        tick++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_ch.valid && sample_ch.ready) || (peak_ch.valid && peak_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  function automatic logic [SampleWidthDef-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:          return {1'b1, {(SampleWidthDef-1){1'b0}}};
      1:          return {1'b0, {(SampleWidthDef-1){1'b1}}};
      2, 3, 4, 5: return SampleWidthDef'(int'($urandom_range(0, 6)) - 3);  // ties
      default:    return $urandom();
    endcase
  endfunction

  // One sample item; opens a new burst with a random gap when the last one ends.
  task automatic feed(input logic [SampleWidthDef-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // Wait for the block to go quiet, then program both grid dimensions.
  task automatic set_dims(input logic [CfgDataW-1:0] rows_raw,
                          input logic [CfgDataW-1:0] cols_raw);
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_NUM_ROWS;
    cfg_data <= rows_raw;
    @(posedge clk_i);
    cfg_idx <= REG_NUM_COLS;
    cfg_data <= cols_raw;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    burst_left = 0;
  endtask

  initial begin : stimulus
    int unsigned         phase;
    int unsigned         count;
    int unsigned         rows_eff;
    int unsigned         cols_eff;
    logic [CfgDataW-1:0] raw_r;
    logic [CfgDataW-1:0] raw_c;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_NUM_ROWS;
    cfg_data <= '0;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 grid out of reset: every sample is its own frame and a peak
    feed(32'h8000_0000);
    feed(32'h7fff_ffff);
    feed(32'h0000_0000);
    feed(32'hffff_ffff);
    // 2x3 with extremes and ties across rows and columns
    set_dims(6'd2, 6'd3);
    feed(32'h8000_0000);
    feed(32'h7fff_ffff);
    feed(32'h7fff_ffff);
    feed(32'h0000_0005);
    feed(32'h7fff_ffff);
    feed(32'hffff_ffff);
    // zero rows acts as one: single row
    set_dims(6'd0, 6'd4);
    feed(32'd3);
    feed(32'd3);
    feed(32'hffff_fff9);
    feed(32'd9);
    // zero columns acts as one: single column
    set_dims(6'd3, 6'd0);
    feed(32'd1);
    feed(32'hffff_ffff);
    feed(32'd1);
    // flat 2x2: all four cells tie
    set_dims(6'd2, 6'd2);
    repeat (4) feed(32'd5);

    phase = 0;
    while (phase < NumPhases) begin
      case (phase)
        1: begin  // rows beyond range clamp to max, tall single column
          raw_r = 6'd40;
          raw_c = 6'd0;
          count = 32;
        end
        3: begin  // widest row, full walk at frame end
          raw_r = 6'd1;
          raw_c = 6'd63;
          count = 32;
        end
        5: begin  // largest grid, left mid-frame
          raw_r = 6'd63;
          raw_c = 6'd32;
          count = $urandom_range(33, 36);
        end
        default: begin
          rows_eff = $urandom_range(1, 3);
          cols_eff = $urandom_range(1, 3);
          raw_r = (rows_eff == 1 && $urandom_range(0, 1) == 1) ? '0 : CfgDataW'(rows_eff);
          raw_c = (cols_eff == 1 && $urandom_range(0, 1) == 1) ? '0 : CfgDataW'(cols_eff);
          count = rows_eff * cols_eff;
          // sometimes stop partway so the next write restarts a frame
          if ($urandom_range(0, 2) == 0) count += $urandom_range(1, rows_eff * cols_eff) - 1;
        end
      endcase
      set_dims(raw_r, raw_c);
      repeat (count) feed(pick_sample());
      phase++;
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
